// ===== rtl/tspa_pkg.sv =====
`default_nettype none

package tspa_pkg;

  localparam int CMD_W   = 1;
  localparam int TYPE_W  = 2;
  localparam int SLOT_W  = 6;
  localparam int COUNT_W = 7;

  localparam logic [CMD_W-1:0] CMD_ALLOC   = 1'b0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ST_NEW     = 2'd0,
    ST_REUSED  = 2'd1,
    ST_FULL    = 2'd2,
    ST_INVALID = 2'd3
  } status_e_t;

  typedef struct packed {
    logic use_in;
    logic latch_in;
    logic al_rd_pos;
    logic capture_last;
    logic commit_alloc;
    logic commit_rel;
  } ctrl_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/tspa_if.sv =====
`default_nettype none

interface tspa_req_if import tspa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [TYPE_W-1:0] obj_type;
  logic [SLOT_W-1:0] slot_id;

  modport source(output valid, cmd, obj_type, slot_id, input ready);
  modport sink(input valid, cmd, obj_type, slot_id, output ready);
endinterface

interface tspa_rsp_if import tspa_pkg::*; ();
  logic               valid;
  logic               ready;
  status_e_t          status;
  logic [SLOT_W-1:0]  out_slot;
  logic [SLOT_W-1:0]  active_pos;
  logic               moved;
  logic [SLOT_W-1:0]  moved_slot;
  logic [COUNT_W-1:0] live_count;

  modport source(output valid, status, out_slot, active_pos, moved, moved_slot, live_count,
                 input ready);
  modport sink(input valid, status, out_slot, active_pos, moved, moved_slot, live_count,
               output ready);
endinterface

`default_nettype wire

// ===== rtl/tspa_ram.sv =====
`default_nettype none

module tspa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/tspa_ctrl.sv =====
`default_nettype none

module tspa_ctrl import tspa_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic [CMD_W-1:0] in_cmd,
  output logic                  in_ready,
  input  wire dp_status_t       dp_st,
  output ctrl_t                 ctrl
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ALLOC = 4'b0010,
    S_REL_A = 4'b0100,
    S_REL_B = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready      = 1'b1;
        ctrl.use_in   = 1'b1;
        ctrl.latch_in = in_valid;
        if (in_valid) begin
          state_next = (in_cmd == CMD_RELEASE) ? S_REL_A : S_ALLOC;
        end
      end
      S_ALLOC: begin
        if (dp_st.out_free) begin
          ctrl.commit_alloc = 1'b1;
          state_next        = S_IDLE;
        end
      end
      S_REL_A: begin
        ctrl.al_rd_pos    = 1'b1;
        ctrl.capture_last = 1'b1;
        state_next        = S_REL_B;
      end
      S_REL_B: begin
        ctrl.al_rd_pos = 1'b1;
        if (dp_st.out_free) begin
          ctrl.commit_rel = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/tspa_dp.sv =====
`default_nettype none

module tspa_dp import tspa_pkg::*; #(
  parameter int NUM_TYPES = 4,
  parameter int MAX_SLOTS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ctrl_t              ctrl,
  output dp_status_t              dp_st,
  input  wire logic [TYPE_W-1:0]  in_obj_type,
  input  wire logic [SLOT_W-1:0]  in_slot_id,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output status_e_t               out_status,
  output logic [SLOT_W-1:0]       out_slot,
  output logic [SLOT_W-1:0]       out_active_pos,
  output logic                    out_moved,
  output logic [SLOT_W-1:0]       out_moved_slot,
  output logic [COUNT_W-1:0]      out_live_count
);

  localparam int SW = $clog2(MAX_SLOTS);
  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int TW = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
  localparam int FD = NUM_TYPES * MAX_SLOTS;
  localparam int FW = $clog2(FD);

  logic [TYPE_W-1:0] type_q;
  logic [SLOT_W-1:0] sid_q;
  logic [CW-1:0]     tops [NUM_TYPES];
  logic [CW-1:0]     active_total;
  logic [CW-1:0]     created;
  logic [SW-1:0]     last_slot;

  logic [TYPE_W-1:0] type_a;
  logic [SLOT_W-1:0] sid_a;
  logic              type_ok;
  logic [TW-1:0]     tidx;
  logic [CW-1:0]     top_a;
  logic [CW-1:0]     last_pos;

  logic          al_we, pos_we, st_we, fs_we;
  logic [SW-1:0] al_waddr, al_wdata, al_raddr, al_rdata;
  logic [SW-1:0] pos_waddr, pos_wdata, pos_rdata;
  logic [TW-1:0] st_rdata;
  logic [FW-1:0] fs_waddr, fs_raddr;
  logic [SW-1:0] fs_rdata;

  logic          reuse, create, alloc_ok;
  logic [SW-1:0] new_slot;
  logic          rel_ok, hole_moved, t_ok, push;
  logic [TW-1:0] t_idx;
  logic [CW-1:0] top_t;

  status_e_t          res_status;
  logic [SLOT_W-1:0]  res_slot, res_pos, res_mslot;
  logic               res_moved;
  logic [COUNT_W-1:0] res_live;
  logic               commit;

  assign type_a   = ctrl.use_in ? in_obj_type : type_q;
  assign sid_a    = ctrl.use_in ? in_slot_id : sid_q;
  assign type_ok  = 32'(type_a) < NUM_TYPES;
  assign tidx     = type_ok ? TW'(type_a) : '0;
  assign top_a    = tops[tidx];
  assign last_pos = active_total - CW'(1);
  assign fs_raddr = FW'(tidx) * FW'(MAX_SLOTS) + FW'(top_a) - FW'(1);
  assign al_raddr = ctrl.al_rd_pos ? pos_rdata : last_pos[SW-1:0];

  // Allocation decision, valid while type_q is the type being allocated.
  assign reuse    = type_ok && (top_a != '0);
  assign create   = type_ok && !reuse && (created < CW'(MAX_SLOTS));
  assign alloc_ok = (reuse || create) && (active_total < CW'(MAX_SLOTS));
  assign new_slot = reuse ? fs_rdata : created[SW-1:0];

  // A slot is live when its recorded index lies in the active list and points back to it.
  assign rel_ok     = (32'(sid_q) < 32'(created)) && (CW'(pos_rdata) < active_total) &&
                      (32'(al_rdata) == 32'(sid_q));
  assign hole_moved = CW'(pos_rdata) != last_pos;
  assign t_ok       = 32'(st_rdata) < NUM_TYPES;
  assign t_idx      = t_ok ? st_rdata : '0;
  assign top_t      = tops[t_idx];
  assign push       = rel_ok && t_ok && (top_t < CW'(MAX_SLOTS));
  assign fs_waddr   = FW'(t_idx) * FW'(MAX_SLOTS) + FW'(top_t);

  assign al_we     = (ctrl.commit_alloc && alloc_ok) ||
                     (ctrl.commit_rel && rel_ok && hole_moved);
  assign al_waddr  = ctrl.commit_alloc ? active_total[SW-1:0] : pos_rdata;
  assign al_wdata  = ctrl.commit_alloc ? new_slot : last_slot;
  assign pos_we    = al_we;
  assign pos_waddr = ctrl.commit_alloc ? new_slot : last_slot;
  assign pos_wdata = ctrl.commit_alloc ? active_total[SW-1:0] : pos_rdata;
  assign st_we     = ctrl.commit_alloc && alloc_ok && create;
  assign fs_we     = ctrl.commit_rel && push;

  tspa_ram #(.WIDTH(SW), .DEPTH(MAX_SLOTS)) u_active_list (
    .clk(clk), .we(al_we), .waddr(al_waddr), .wdata(al_wdata),
    .raddr(al_raddr), .rdata(al_rdata)
  );

  tspa_ram #(.WIDTH(SW), .DEPTH(MAX_SLOTS)) u_slot_pos (
    .clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
    .raddr(SW'(sid_a)), .rdata(pos_rdata)
  );

  tspa_ram #(.WIDTH(TW), .DEPTH(MAX_SLOTS)) u_slot_type (
    .clk(clk), .we(st_we), .waddr(created[SW-1:0]), .wdata(tidx),
    .raddr(SW'(sid_a)), .rdata(st_rdata)
  );

  tspa_ram #(.WIDTH(SW), .DEPTH(FD)) u_free_stacks (
    .clk(clk), .we(fs_we), .waddr(fs_waddr), .wdata(SW'(sid_q)),
    .raddr(fs_raddr), .rdata(fs_rdata)
  );

  always_comb begin
    if (ctrl.commit_alloc) begin
      res_status = !alloc_ok ? ST_FULL : (reuse ? ST_REUSED : ST_NEW);
      res_slot   = alloc_ok ? SLOT_W'(new_slot) : '0;
      res_pos    = alloc_ok ? SLOT_W'(active_total) : '0;
      res_moved  = 1'b0;
      res_mslot  = '0;
      res_live   = alloc_ok ? COUNT_W'(active_total + CW'(1)) : COUNT_W'(active_total);
    end else begin
      res_status = rel_ok ? ST_REUSED : ST_INVALID;
      res_slot   = sid_q;
      res_pos    = rel_ok ? SLOT_W'(pos_rdata) : '0;
      res_moved  = rel_ok && hole_moved;
      res_mslot  = (rel_ok && hole_moved) ? SLOT_W'(last_slot) : '0;
      res_live   = rel_ok ? COUNT_W'(last_pos) : COUNT_W'(active_total);
    end
  end

  assign commit          = ctrl.commit_alloc || ctrl.commit_rel;
  assign dp_st.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (ctrl.latch_in) begin
      type_q <= in_obj_type;
      sid_q  <= in_slot_id;
    end
    if (ctrl.capture_last) begin
      last_slot <= al_rdata;
    end
    if (commit) begin
      out_status     <= res_status;
      out_slot       <= res_slot;
      out_active_pos <= res_pos;
      out_moved      <= res_moved;
      out_moved_slot <= res_mslot;
      out_live_count <= res_live;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      active_total <= '0;
      created      <= '0;
      for (int i = 0; i < NUM_TYPES; i++) begin
        tops[i] <= '0;
      end
    end else begin
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (ctrl.commit_alloc && alloc_ok) begin
        active_total <= active_total + CW'(1);
        if (create) begin
          created <= created + CW'(1);
        end else begin
          tops[tidx] <= top_a - CW'(1);
        end
      end
      if (ctrl.commit_rel && rel_ok) begin
        active_total <= last_pos;
        if (push) begin
          tops[t_idx] <= top_t + CW'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/typed_slot_pool_allocator.sv =====
// Typed slot pool allocator.
// Commands arrive on the req channel (cmd, obj_type, slot_id) and each one yields
// exactly one result on the rsp channel (status, out_slot, active_pos, moved,
// moved_slot, live_count). A transfer happens when valid and ready are both high.
// An allocate reads the type's free stack in its transfer cycle; then, in the
// allocate state and once the output register is free, the active list and
// counters are updated and the result is registered. A release reads the
// slot's recorded index and the last active entry in the transfer cycle, then
// reads the active list entry at that index to confirm the slot is live, then,
// once the output register is free, writes the swap and the free stack push and
// registers its result. The chain of dependent reads through the active list
// memory sets this sequence, and a new command is taken only after the previous
// one has been registered.
// The result sits in an output register; a new command is taken while it waits,
// but the next result is held back, and no further command is taken, until the
// receiver takes the previous one.
// A synchronous reset empties the active list and all free stacks and forgets
// every created slot; the memories themselves need no clearing pass.

`default_nettype none

module typed_slot_pool_allocator import tspa_pkg::*; #(
  parameter int NUM_TYPES = 4,
  parameter int MAX_SLOTS = 64
) (
  input wire logic  clk,
  input wire logic  rst,
  tspa_req_if.sink  req,
  tspa_rsp_if.source rsp
);

  ctrl_t      ctrl;
  dp_status_t dp_st;

  tspa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_cmd   (req.cmd),
    .in_ready (req.ready),
    .dp_st    (dp_st),
    .ctrl     (ctrl)
  );

  tspa_dp #(.NUM_TYPES(NUM_TYPES), .MAX_SLOTS(MAX_SLOTS)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (ctrl),
    .dp_st          (dp_st),
    .in_obj_type    (req.obj_type),
    .in_slot_id     (req.slot_id),
    .out_valid      (rsp.valid),
    .out_ready      (rsp.ready),
    .out_status     (rsp.status),
    .out_slot       (rsp.out_slot),
    .out_active_pos (rsp.active_pos),
    .out_moved      (rsp.moved),
    .out_moved_slot (rsp.moved_slot),
    .out_live_count (rsp.live_count)
  );

endmodule

`default_nettype wire

// ===== rtl/tspa_chk.sv =====
`default_nettype none

module tspa_chk import tspa_pkg::*; #(
  parameter int MAX_SLOTS = 64
) (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               rsp_valid,
  input wire logic               rsp_ready,
  input wire status_e_t          rsp_status,
  input wire logic [SLOT_W-1:0]  rsp_out_slot,
  input wire logic [SLOT_W-1:0]  rsp_active_pos,
  input wire logic               rsp_moved,
  input wire logic [SLOT_W-1:0]  rsp_moved_slot,
  input wire logic [COUNT_W-1:0] rsp_live_count
);

  a_rst_clears_rsp: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid &&
      $stable({rsp_status, rsp_out_slot, rsp_active_pos, rsp_moved, rsp_moved_slot,
               rsp_live_count}))
    else $error("stalled result changed");

  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> 32'(rsp_live_count) <= MAX_SLOTS)
    else $error("live count beyond pool size");

  a_refused_quiet: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == ST_FULL || rsp_status == ST_INVALID) |->
      !rsp_moved && rsp_active_pos == '0 && rsp_moved_slot == '0)
    else $error("refused command reports movement");

  a_move_is_release: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_moved |-> rsp_status == ST_REUSED && rsp_moved_slot != rsp_out_slot)
    else $error("moved slot on a non-release result");

endmodule

bind typed_slot_pool_allocator tspa_chk #(.MAX_SLOTS(MAX_SLOTS)) u_tspa_chk (
  .clk            (clk),
  .rst            (rst),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_status     (rsp.status),
  .rsp_out_slot   (rsp.out_slot),
  .rsp_active_pos (rsp.active_pos),
  .rsp_moved      (rsp.moved),
  .rsp_moved_slot (rsp.moved_slot),
  .rsp_live_count (rsp.live_count)
);

`default_nettype wire
